FILE: design/deadline_timer_heap_queue_macros.svh
// ----------------------------------------------------------------------------
// deadline_timer_heap_queue_macros
// Assertion macros for the deadline timer heap queue.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_HEAP_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_HEAP_QUEUE_MACROS_SVH
// assert that an antecedent implies a consequent in the next cycle
`define DTHQ_ASSERT_NEXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// assert that a condition holds on every cycle
`define DTHQ_ASSERT_ALWAYS(label, rst, cond) \
   label: assert property (@(posedge clock) disable iff (rst) (cond)) \
      else $error("assertion failed");
`endif

FILE: design/dthq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dthq_pkg
// Types and constants shared by the deadline timer heap queue.
// ----------------------------------------------------------------------------
package dthq_pkg;
   localparam int HEAP_DEPTH_DEF   = 64;
   localparam int HANDLE_COUNT_DEF = 1024;
   localparam int TAG_BITS_DEF     = 8;
   localparam int HANDLE_W = 10;
   localparam int TIMEOUT_W = 32;
   localparam int TIME_W = 40;
   localparam int WAIT_W = 31;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_EXPIRE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_TOP_RD,
      ST_TOP_LV,
      ST_TOP_CHK,
      ST_POP_RD,
      ST_POP_WR,
      ST_DN_RD,
      ST_DN_CMP,
      ST_LV_CLR,
      ST_OUT
   } state_type;
endpackage

FILE: design/deadline_timer_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_heap_queue
// Min-heap of deadlines with lazy cancellation, expire and query.
// ----------------------------------------------------------------------------
// channel  direction  handshake
// req      in         req_valid / req_ready
// rsp      out        rsp_valid / rsp_ready
// An add climbs the heap one level at a time; a cancel clears the live entry.
// Query and expire check the top entry, pop stale (and, for expire, due)
// entries and sift down; expire sends one response per expired handle.
// Reset starts a pass that clears the live table before requests are taken.
// A stalled response holds the sequencer; req_ready is low while busy.
module deadline_timer_heap_queue #(
   parameter int HEAP_DEPTH   = dthq_pkg::HEAP_DEPTH_DEF,
   parameter int HANDLE_COUNT = dthq_pkg::HANDLE_COUNT_DEF,
   parameter int TAG_BITS     = dthq_pkg::TAG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [dthq_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [dthq_pkg::TIMEOUT_W-1:0] req_timeout_ms,
   input  logic [dthq_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dthq_pkg::HANDLE_W-1:0]  rsp_expired_handle,
   output logic                           rsp_expired_valid,
   output logic [dthq_pkg::WAIT_W-1:0]    rsp_wait_ms,
   output logic                           rsp_no_timer,
   output logic                           rsp_full_error,
   output logic                           rsp_last
);
   import dthq_pkg::*;
   `include "deadline_timer_heap_queue_macros.svh"

   localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int LW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
   localparam int VW = ((LW > HANDLE_W) ? LW : HANDLE_W) + 1;

   typedef struct packed {
      logic [TIME_W-1:0]   dl;
      logic [HANDLE_W-1:0] own;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic                valid;
      logic [TAG_BITS-1:0] tag;
   } live_type;

   entry_type heap_mem [HEAP_DEPTH];
   live_type live_mem [HANDLE_COUNT];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   mode_type mode_ff, mode_in;
   logic [HANDLE_W-1:0] hnd_ff, hnd_in;
   logic [TIME_W-1:0] now_ff, now_in;
   entry_type cur_ff, cur_in;   // entry being sifted
   entry_type a_ff, a_in;       // first fetched entry
   logic [CW:0] idx_ff, idx_in; // current position
   logic [CW:0] pos_ff, pos_in; // compared position
   logic phase_ff, phase_in;
   logic any_ff, any_in;        // an expired handle waits to be sent
   logic [HANDLE_W-1:0] ph_ff, ph_in;
   logic [LW-1:0] clr_ff, clr_in;
   logic [HANDLE_W-1:0] oh_ff, oh_in;
   logic [WAIT_W-1:0] ow_ff, ow_in;
   logic onone_ff, onone_in, ofull_ff, ofull_in, oev_ff, oev_in, olast_ff, olast_in;

   logic h_we; logic [IW-1:0] h_wa, h_ra; entry_type h_wd, h_rd;
   logic l_we; logic [LW-1:0] l_wa, l_ra; live_type l_wd, l_rd;

   always_ff @(posedge clock) begin
      if (h_we) heap_mem[h_wa] <= h_wd;
      h_rd <= heap_mem[h_ra];
      if (l_we) live_mem[l_wa] <= l_wd;
      l_rd <= live_mem[l_ra];
   end

   logic [TIME_W:0] sum;
   logic [TIME_W-1:0] diff;
   logic hnd_ok, req_in_range, stale, due, full, heap_empty, pop_last;
   logic dn_leaf, right_ok, sink, expire_more;
   logic [TIME_W-1:0] child_dl;
   logic [VW-1:0] hnd_ext, own_ext;
   logic [CW:0] lidx;
   assign sum = {1'b0, now_ff} + {{(TIME_W-TIMEOUT_W+1){1'b0}}, a_ff.dl[TIMEOUT_W-1:0]};
   assign diff = a_ff.dl - now_ff;
   assign hnd_ext = VW'(hnd_ff);
   assign own_ext = VW'(a_ff.own);
   assign hnd_ok = hnd_ext < VW'(HANDLE_COUNT);
   assign req_in_range = VW'(req_handle) < VW'(HANDLE_COUNT);
   assign lidx = (idx_ff << 1) + (CW+1)'(1);
   assign stale = own_ext >= VW'(HANDLE_COUNT) || !l_rd.valid || l_rd.tag != a_ff.tag;
   assign due = a_ff.dl <= now_ff;
   assign full = count_ff == CW'(HEAP_DEPTH);
   assign heap_empty = count_ff == '0;
   assign pop_last = count_ff == CW'(1);
   assign dn_leaf = lidx >= (CW+1)'(count_ff);
   assign right_ok = (pos_ff + 1'b1 < (CW+1)'(count_ff)) && (h_rd.dl < a_ff.dl);
   assign child_dl = right_ok ? h_rd.dl : a_ff.dl;
   assign sink = child_dl < cur_ff.dl;
   assign expire_more = (mode_ff == MODE_EXPIRE) && oev_ff && !olast_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LV_CLR: if (clr_ff == LW'(HANDLE_COUNT - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               unique case (mode_type'(req_mode))
                  MODE_ADD:    state_in = ST_UP_RD;
                  MODE_CANCEL: state_in = ST_OUT;
                  default:     state_in = ST_TOP_RD;
               endcase
            end
         end
         ST_UP_RD: state_in = (!hnd_ok || full) ? ST_OUT : ST_UP_CMP;
         ST_UP_CMP: begin
            if (!phase_ff) begin
               if (idx_ff == '0) state_in = ST_OUT;
            end else if (!(h_rd.dl > cur_ff.dl)) state_in = ST_OUT;
         end
         ST_TOP_RD: state_in = heap_empty ? ST_OUT : ST_TOP_LV;
         ST_TOP_LV: state_in = ST_TOP_CHK;
         ST_TOP_CHK: begin
            if (stale) state_in = ST_POP_RD;
            else if (mode_ff == MODE_EXPIRE && due && !any_ff) state_in = ST_POP_RD;
            else state_in = ST_OUT;
         end
         ST_POP_RD: state_in = pop_last ? ST_TOP_RD : ST_POP_WR;
         ST_POP_WR: state_in = ST_DN_RD;
         ST_DN_RD: begin
            if (!phase_ff) begin
               if (dn_leaf) state_in = ST_TOP_RD;
            end else state_in = ST_DN_CMP;
         end
         ST_DN_CMP: state_in = sink ? ST_DN_RD : ST_TOP_RD;
         ST_OUT: begin
            if (rsp_ready) state_in = expire_more ? ST_POP_RD : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff; tag_in = tag_ff; mode_in = mode_ff;
      hnd_in = hnd_ff; now_in = now_ff; cur_in = cur_ff; a_in = a_ff;
      idx_in = idx_ff; pos_in = pos_ff; phase_in = phase_ff; any_in = any_ff;
      ph_in = ph_ff; clr_in = clr_ff;
      oh_in = oh_ff; ow_in = ow_ff; onone_in = onone_ff; ofull_in = ofull_ff;
      oev_in = oev_ff; olast_in = olast_ff;
      h_we = 1'b0; h_wa = idx_ff[IW-1:0]; h_wd = cur_ff; h_ra = '0;
      l_we = 1'b0; l_wa = LW'(hnd_ff); l_wd.valid = 1'b1; l_wd.tag = tag_ff;
      l_ra = LW'(a_ff.own);
      unique case (state_ff)
         ST_LV_CLR: begin
            l_we = 1'b1; l_wa = clr_ff; l_wd = '0; clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = mode_type'(req_mode); hnd_in = req_handle; now_in = req_now_ms;
               a_in = '0; a_in.dl[TIMEOUT_W-1:0] = req_timeout_ms;
               any_in = 1'b0;
               oh_in = '0; ow_in = '0; onone_in = 1'b0; ofull_in = 1'b0;
               oev_in = 1'b0; olast_in = 1'b1;
               if (mode_type'(req_mode) == MODE_CANCEL && req_in_range) begin
                  l_we = 1'b1; l_wa = LW'(req_handle); l_wd = '0;
               end
            end
         end
         ST_UP_RD: begin
            if (hnd_ok && full) ofull_in = 1'b1;
            else if (hnd_ok) begin
               cur_in.dl = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
               cur_in.own = hnd_ff; cur_in.tag = tag_ff;
               l_we = 1'b1;
               tag_in = tag_ff + 1'b1;
               idx_in = (CW+1)'(count_ff);
               count_in = count_ff + 1'b1;
               phase_in = 1'b0;
            end
         end
         ST_UP_CMP: begin
            // phase 0: issue parent read; phase 1: compare
            pos_in = (idx_ff - 1'b1) >> 1;
            h_ra = pos_in[IW-1:0];
            if (!phase_ff) begin
               if (idx_ff == '0) h_we = 1'b1;
               else phase_in = 1'b1;
            end else begin
               phase_in = 1'b0; h_we = 1'b1;
               if (h_rd.dl > cur_ff.dl) begin
                  h_wd = h_rd; idx_in = pos_ff;
               end
            end
         end
         ST_TOP_RD: begin
            if (heap_empty) begin
               if (mode_ff == MODE_QUERY) onone_in = 1'b1;
               else if (any_ff) begin
                  oh_in = ph_ff; oev_in = 1'b1; olast_in = 1'b1; any_in = 1'b0;
               end
            end
         end
         ST_TOP_LV: begin
            a_in = h_rd; l_ra = LW'(h_rd.own);
         end
         ST_TOP_CHK: begin
            if (!stale) begin
               if (mode_ff == MODE_QUERY) begin
                  ow_in = due ? '0 :
                          (diff > TIME_W'({WAIT_W{1'b1}})) ? '1 : diff[WAIT_W-1:0];
               end else if (due) begin
                  l_we = 1'b1; l_wa = LW'(a_ff.own); l_wd = '0;
                  ph_in = a_ff.own; any_in = 1'b1;
                  if (any_ff) begin
                     oh_in = ph_ff; oev_in = 1'b1; olast_in = 1'b0;
                  end
               end else if (any_ff) begin
                  oh_in = ph_ff; oev_in = 1'b1; olast_in = 1'b1; any_in = 1'b0;
               end
            end
         end
         ST_POP_RD: begin
            count_in = count_ff - 1'b1;
            h_ra = count_in[IW-1:0];
         end
         ST_POP_WR: begin
            cur_in = h_rd; idx_in = '0; phase_in = 1'b0;
         end
         ST_DN_RD: begin
            // phase 0 reads left child, phase 1 captures it and reads right
            if (!phase_ff) begin
               h_ra = lidx[IW-1:0];
               if (dn_leaf) h_we = 1'b1;
               else phase_in = 1'b1;
            end else begin
               a_in = h_rd; h_ra = IW'(lidx + 1'b1); pos_in = lidx;
               phase_in = 1'b0;
            end
         end
         ST_DN_CMP: begin
            h_we = 1'b1;
            if (sink) begin
               h_wd = right_ok ? h_rd : a_ff;
               idx_in = right_ok ? pos_ff + 1'b1 : pos_ff;
            end
         end
         ST_OUT: begin
            if (rsp_ready && expire_more) begin
               oev_in = 1'b0; oh_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LV_CLR; count_ff <= '0; tag_ff <= '0; clr_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; tag_ff <= tag_in; clr_ff <= clr_in;
      end
      mode_ff <= mode_in; hnd_ff <= hnd_in; now_ff <= now_in; cur_ff <= cur_in;
      a_ff <= a_in; idx_ff <= idx_in; pos_ff <= pos_in; phase_ff <= phase_in;
      any_ff <= any_in; ph_ff <= ph_in; oh_ff <= oh_in; ow_ff <= ow_in;
      onone_ff <= onone_in; ofull_ff <= ofull_in; oev_ff <= oev_in; olast_ff <= olast_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_expired_handle = oh_ff;
   assign rsp_expired_valid = oev_ff;
   assign rsp_wait_ms = ow_ff;
   assign rsp_no_timer = onone_ff;
   assign rsp_full_error = ofull_ff;
   assign rsp_last = olast_ff;

   `DTHQ_ASSERT_ALWAYS(a_cnt, reset, count_ff <= CW'(HEAP_DEPTH))
   `DTHQ_ASSERT_ALWAYS(a_rdy, reset, !(req_ready && rsp_valid))
   `DTHQ_ASSERT_NEXT(a_acc, reset, req_valid && req_ready, !req_ready)
   `DTHQ_ASSERT_NEXT(a_hold, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

FILE: dv/deadline_timer_heap_queue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_heap_queue_checker
// Watches the request and response channels of the timer heap queue. It keeps
// its own min-heap with lazy cancellation, works out the responses that each
// request should produce and compares every response field by field.
// ----------------------------------------------------------------------------
module deadline_timer_heap_queue_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [dthq_pkg::HANDLE_W-1:0]  req_handle,
   input  logic [dthq_pkg::TIMEOUT_W-1:0] req_timeout_ms,
   input  logic [dthq_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [dthq_pkg::HANDLE_W-1:0]  rsp_expired_handle,
   input  logic                           rsp_expired_valid,
   input  logic [dthq_pkg::WAIT_W-1:0]    rsp_wait_ms,
   input  logic                           rsp_no_timer,
   input  logic                           rsp_full_error,
   input  logic                           rsp_last,
   output int                             error_count,
   output int                             pending_count
);
   import dthq_pkg::*;

   localparam int DEPTH = HEAP_DEPTH_DEF;
   localparam int HCNT  = HANDLE_COUNT_DEF;
   localparam logic [TIME_W-1:0] TIME_TOP = '1;
   localparam logic [WAIT_W-1:0] WAIT_TOP = '1;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic                hit;
      logic [WAIT_W-1:0]   wait_ms;
      logic                no_timer;
      logic                full;
      logic                last;
   } timer_rsp_type;

   logic [TIME_W-1:0]       hp_deadline [DEPTH];
   logic [HANDLE_W-1:0]     hp_owner    [DEPTH];
   logic [TAG_BITS_DEF-1:0] hp_tag      [DEPTH];
   int                      hp_count;
   logic [TAG_BITS_DEF-1:0] owner_tag   [HCNT];
   logic                    owner_live  [HCNT];
   logic [TAG_BITS_DEF-1:0] tag_next;
   timer_rsp_type           expected_rsps [$];

   function automatic timer_rsp_type make_rsp(logic [HANDLE_W-1:0] h, logic hit,
                                              logic [WAIT_W-1:0] w, logic nt,
                                              logic fe, logic lst);
      timer_rsp_type r;
      r.handle = h; r.hit = hit; r.wait_ms = w;
      r.no_timer = nt; r.full = fe; r.last = lst;
      return r;
   endfunction

   task automatic swap_entries(int a, int b);
      logic [TIME_W-1:0]       d;
      logic [HANDLE_W-1:0]     o;
      logic [TAG_BITS_DEF-1:0] t;
      d = hp_deadline[a]; o = hp_owner[a]; t = hp_tag[a];
      hp_deadline[a] = hp_deadline[b]; hp_owner[a] = hp_owner[b];
      hp_tag[a] = hp_tag[b];
      hp_deadline[b] = d; hp_owner[b] = o; hp_tag[b] = t;
   endtask

   task automatic remove_root();
      int i, l, r, c;
      i = 0;
      if (hp_count == 0) return;
      hp_count--;
      if (hp_count == 0) return;
      hp_deadline[0] = hp_deadline[hp_count];
      hp_owner[0] = hp_owner[hp_count];
      hp_tag[0] = hp_tag[hp_count];
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         if (l >= hp_count) break;
         c = l;
         if (r < hp_count && hp_deadline[r] < hp_deadline[l]) c = r;
         if (!(hp_deadline[c] < hp_deadline[i])) break;
         swap_entries(i, c);
         i = c;
      end
   endtask

   task automatic discard_cancelled();
      while (hp_count > 0 && (!owner_live[hp_owner[0]] ||
                              owner_tag[hp_owner[0]] != hp_tag[0]))
         remove_root();
   endtask

   task automatic predict_request(logic [1:0] m, logic [HANDLE_W-1:0] h,
                                  logic [TIMEOUT_W-1:0] tmo, logic [TIME_W-1:0] now);
      logic [TIME_W:0]  sum;
      logic [TIME_W-1:0] diff;
      int               i, p, n;
      case (mode_type'(m))
         MODE_ADD: begin
            if (hp_count >= DEPTH) begin
               expected_rsps.push_back(make_rsp('0, 0, '0, 0, 1, 1));
            end else begin
               sum = {1'b0, now} + {{(TIME_W-TIMEOUT_W+1){1'b0}}, tmo};
               i = hp_count;
               hp_deadline[i] = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
               hp_owner[i] = h;
               hp_tag[i] = tag_next;
               hp_count++;
               owner_tag[h] = tag_next;
               owner_live[h] = 1;
               tag_next++;
               while (i > 0) begin
                  p = (i - 1) / 2;
                  if (!(hp_deadline[p] > hp_deadline[i])) break;
                  swap_entries(i, p);
                  i = p;
               end
               expected_rsps.push_back(make_rsp('0, 0, '0, 0, 0, 1));
            end
         end
         MODE_CANCEL: begin
            owner_live[h] = 0;
            expected_rsps.push_back(make_rsp('0, 0, '0, 0, 0, 1));
         end
         MODE_EXPIRE: begin
            n = 0;
            forever begin
               discard_cancelled();
               if (hp_count == 0 || hp_deadline[0] > now) break;
               expected_rsps.push_back(make_rsp(hp_owner[0], 1, '0, 0, 0, 0));
               n++;
               owner_live[hp_owner[0]] = 0;
               remove_root();
            end
            if (n == 0) expected_rsps.push_back(make_rsp('0, 0, '0, 0, 0, 1));
            else expected_rsps[$].last = 1;
         end
         default: begin
            discard_cancelled();
            if (hp_count == 0) begin
               expected_rsps.push_back(make_rsp('0, 0, '0, 1, 0, 1));
            end else begin
               diff = (hp_deadline[0] > now) ? hp_deadline[0] - now : '0;
               expected_rsps.push_back(make_rsp('0, 0,
                  (diff > TIME_W'(WAIT_TOP)) ? WAIT_TOP : diff[WAIT_W-1:0], 0, 0, 1));
            end
         end
      endcase
   endtask

   timer_rsp_type got, want;

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      if (reset) begin
         hp_count = 0;
         tag_next = '0;
         for (int k = 0; k < HCNT; k++) owner_live[k] = 0;
         expected_rsps.delete();
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = make_rsp(rsp_expired_handle, rsp_expired_valid, rsp_wait_ms,
                           rsp_no_timer, rsp_full_error, rsp_last);
            if (expected_rsps.size() == 0) begin
               if (error_count < 10) $display("unexpected response %p", got);
               error_count <= error_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  if (error_count < 10)
                     $display("mismatch: expected %p actual %p", want, got);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            predict_request(req_mode, req_handle, req_timeout_ms, req_now_ms);
      end
   end
endmodule

FILE: dv/tb_deadline_timer_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_timer_heap_queue
// Drives directed and random timer requests into the heap queue with random
// idle and stall cycles; the checker predicts and compares the responses.
// ----------------------------------------------------------------------------
module tb_deadline_timer_heap_queue;
   import dthq_pkg::*;

   logic                 clock, reset;
   logic                 req_valid, req_ready;
   logic [1:0]           req_mode;
   logic [HANDLE_W-1:0]  req_handle;
   logic [TIMEOUT_W-1:0] req_timeout_ms;
   logic [TIME_W-1:0]    req_now_ms;
   logic                 rsp_valid, rsp_ready;
   logic [HANDLE_W-1:0]  rsp_expired_handle;
   logic                 rsp_expired_valid;
   logic [WAIT_W-1:0]    rsp_wait_ms;
   logic                 rsp_no_timer, rsp_full_error, rsp_last;
   int                   error_count, pending_count;
   int                   cycle_count;
   logic                 calm;
   logic [TIME_W-1:0]    clock_ms;

   deadline_timer_heap_queue dut (.*);

   deadline_timer_heap_queue_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready <= calm || ($urandom_range(99) >= 25);
      if (cycle_count > 2000000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_request(mode_type m, logic [HANDLE_W-1:0] h,
                               logic [TIMEOUT_W-1:0] tmo, logic [TIME_W-1:0] now);
      while (!calm && $urandom_range(99) < 25) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= m;
      req_handle <= h;
      req_timeout_ms <= tmo;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_request(int n);
      int pick;
      pick = $urandom_range(99);
      clock_ms = clock_ms + TIME_W'($urandom_range(40));
      if (pick < 45)
         send_request(MODE_ADD, HANDLE_W'($urandom_range(n)),
                      ($urandom_range(9) == 0) ? $urandom : $urandom_range(200),
                      clock_ms);
      else if (pick < 65)
         send_request(MODE_CANCEL, HANDLE_W'($urandom_range(n)), $urandom, clock_ms);
      else if (pick < 85)
         send_request(MODE_EXPIRE, HANDLE_W'($urandom), $urandom, clock_ms);
      else
         send_request(MODE_QUERY, HANDLE_W'($urandom), $urandom, clock_ms);
   endtask

   initial begin
      cycle_count = 0;
      calm = 0;
      reset = 1;
      req_valid = 0;
      req_mode = MODE_ADD;
      req_handle = '0;
      req_timeout_ms = '0;
      req_now_ms = '0;
      rsp_ready = 0;
      clock_ms = 40'd1000;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_request(MODE_QUERY, 0, 0, 0);
      send_request(MODE_EXPIRE, 0, 0, 0);
      send_request(MODE_ADD, 10'd1023, '1, '1);
      send_request(MODE_ADD, 0, 0, 0);
      send_request(MODE_ADD, 5, 100, 0);
      send_request(MODE_ADD, 5, 50, 0);
      send_request(MODE_ADD, 7, 30, 0);
      send_request(MODE_CANCEL, 7, 0, 0);
      send_request(MODE_CANCEL, 9, 0, 0);
      send_request(MODE_ADD, 9, '1, 40'hFF_FFFF_0000);
      send_request(MODE_QUERY, 0, 0, 0);
      send_request(MODE_EXPIRE, 0, 0, 60);
      send_request(MODE_QUERY, 0, 0, 60);
      send_request(MODE_QUERY, 0, 0, 40'hFF_FFFF_FFFF);
      send_request(MODE_EXPIRE, 0, 0, 40'hFF_FFFF_FFFF);
      for (int k = 0; k < 66; k++)
         send_request(MODE_ADD, HANDLE_W'(k % 3), 32'(k), 40'd500);
      send_request(MODE_EXPIRE, 0, 0, 40'd600);
      calm = 1;
      for (int k = 0; k < 100; k++) send_request(MODE_ADD, HANDLE_W'(k), 5, clock_ms);
      send_request(MODE_EXPIRE, 0, 0, clock_ms + 10);
      calm = 0;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0 && cycle_count < 1900000) @(posedge clock);
      for (int k = 0; k < 150; k++) random_request(($urandom_range(1)) ? 15 : 1023);
      for (int k = 0; k < 150; k++) random_request(7);
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0 && cycle_count < 1900000) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
